@@ hdl/cell_liveness_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cell liveness table unit
// Implication checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CELL_LIVENESS_TABLE_UNIT_MACROS_SVH
`define CELL_LIVENESS_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define CLT_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
`define CLT_ASSERT_NXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`else
`define CLT_ASSERT_IMP(lbl, a, c, msg)
`define CLT_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

@@ hdl/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// Cell liveness table package
// Command and event codes, entry layout, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam logic [1:0] CMD_ACK  = 2'd0;
	localparam logic [1:0] CMD_MSG  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [1:0] EV_CHANGED = 2'd0;
	localparam logic [1:0] EV_LOST    = 2'd1;
	localparam logic [1:0] EV_FORWARD = 2'd2;
	localparam logic [1:0] EV_FULL    = 2'd3;

	localparam logic [31:0] STALE_RESET_MS = 32'd2000;

	typedef struct packed {
		logic [63:0]        station;
		logic [31:0]        cell_id;
		logic signed [15:0] level;
		logic [31:0]        seen;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESPOND,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic respond;
		logic flush;
	} ctl_t;

	typedef struct packed {
		logic scan_done;
		logic is_tick;
		logic out_free;
		logic pend;
	} stat_t;

endpackage

@@ hdl/clt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Cell liveness table controller
// Sequences load, table scan, then either response or final flush of one item.
// ----------------------------------------------------------------------------
module clt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  clt_pkg::stat_t st,
	output clt_pkg::ctl_t  ctl
);

	clt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clt_pkg::ST_IDLE: begin
				if (in_valid) state_d = clt_pkg::ST_SCAN;
			end
			clt_pkg::ST_SCAN: begin
				if (st.scan_done) state_d = st.is_tick ? clt_pkg::ST_FLUSH : clt_pkg::ST_RESPOND;
			end
			clt_pkg::ST_RESPOND: begin
				if (st.out_free) state_d = clt_pkg::ST_IDLE;
			end
			clt_pkg::ST_FLUSH: begin
				if (!st.pend || st.out_free) state_d = clt_pkg::ST_IDLE;
			end
			default: state_d = clt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == clt_pkg::ST_IDLE);
		ctl.load    = (state_q == clt_pkg::ST_IDLE) && in_valid;
		ctl.scan    = (state_q == clt_pkg::ST_SCAN);
		ctl.respond = (state_q == clt_pkg::ST_RESPOND);
		ctl.flush   = (state_q == clt_pkg::ST_FLUSH);
	end

endmodule

@@ hdl/clt_dp.sv @@
// ----------------------------------------------------------------------------
// Cell liveness table datapath
// Entry memory, valid bits, scan pipeline, cell counter, threshold
// register and the output register.
// ----------------------------------------------------------------------------
`include "cell_liveness_table_unit_macros.svh"

module clt_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clt_pkg::ctl_t      ctl,
	output clt_pkg::stat_t     st,
	input  logic [1:0]         command,
	input  logic [63:0]        station_id,
	input  logic signed [15:0] signal_dbm,
	input  logic [31:0]        now_ms,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_res,
	output logic [31:0]        cell_number,
	output logic signed [15:0] level_dbm,
	output logic               last
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW:0] DEPTH_C = (IW + 1)'(TABLE_DEPTH);

	clt_pkg::entry_t mem [TABLE_DEPTH];
	clt_pkg::entry_t rdata_s1;
	logic            ev_valid_s1;
	logic [IW-1:0]   ev_idx_s1;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IW:0]            iss_q;
	logic [31:0]            thr_q;
	logic [31:0]            counter_q;

	logic [1:0]         cmd_q;
	logic [63:0]        key_q;
	logic signed [15:0] lvl_q;
	logic [31:0]        now_q;

	logic               hit_q, free_found_q, pend_q;
	logic [IW-1:0]      hit_idx_q, free_idx_q;
	logic [31:0]        hit_cell_q, pend_cell_q;
	logic signed [15:0] hit_level_q;

	logic               out_valid_q, out_last_q;
	logic [1:0]         out_ev_q;
	logic [31:0]        out_cell_q;
	logic signed [15:0] out_level_q;

	logic               is_tick, is_ack, is_msg, out_free;
	logic               ev_live, remove, match, empty, stall, advance, rd_en;
	logic [31:0]        age, next_cell;
	logic               respond_go, ins_en, wr_en, scan_push, flush_push, resp_push, push;
	logic [IW-1:0]      wr_idx;
	clt_pkg::entry_t    wr_data;
	logic [1:0]         push_ev;
	logic [31:0]        push_cell;
	logic signed [15:0] push_level;
	logic               push_last;

	assign is_tick  = (cmd_q == clt_pkg::CMD_TICK);
	assign is_ack   = (cmd_q == clt_pkg::CMD_ACK);
	assign is_msg   = (cmd_q == clt_pkg::CMD_MSG);
	assign out_free = !out_valid_q || out_ready;

	assign ev_live = valid_q[ev_idx_s1];
	assign age     = now_q - rdata_s1.seen;
	assign remove  = ev_valid_s1 && is_tick && ev_live && (age > thr_q);
	assign match   = ev_valid_s1 && ev_live && (rdata_s1.station == key_q);
	assign empty   = ev_valid_s1 && !ev_live;
	assign stall   = remove && pend_q && !out_free;
	assign advance = ctl.scan && !stall;
	assign rd_en   = advance && (iss_q < DEPTH_C);

	assign next_cell  = counter_q + 32'd1;
	assign respond_go = ctl.respond && out_free;
	assign ins_en     = respond_go && is_ack && !hit_q && free_found_q;
	assign wr_en      = respond_go && is_ack && (hit_q || free_found_q);
	assign wr_idx     = hit_q ? hit_idx_q : free_idx_q;

	always_comb begin
		wr_data.station = key_q;
		wr_data.cell_id = hit_q ? hit_cell_q : next_cell;
		wr_data.level   = lvl_q;
		wr_data.seen    = now_q;
	end

	assign scan_push  = remove && pend_q && advance;
	assign flush_push = ctl.flush && pend_q && out_free;

	always_comb begin
		resp_push  = 1'b0;
		push_ev    = clt_pkg::EV_LOST;
		push_cell  = pend_cell_q;
		push_level = 16'sd0;
		push_last  = flush_push;
		if (respond_go) begin
			push_last = 1'b1;
			if (is_ack) begin
				if (hit_q) begin
					resp_push  = (hit_level_q != lvl_q);
					push_ev    = clt_pkg::EV_CHANGED;
					push_cell  = hit_cell_q;
					push_level = lvl_q;
				end else if (free_found_q) begin
					resp_push  = 1'b1;
					push_ev    = clt_pkg::EV_CHANGED;
					push_cell  = next_cell;
					push_level = lvl_q;
				end else begin
					resp_push = 1'b1;
					push_ev   = clt_pkg::EV_FULL;
					push_cell = 32'd0;
				end
			end else if (is_msg) begin
				resp_push = hit_q;
				push_ev   = clt_pkg::EV_FORWARD;
				push_cell = hit_cell_q;
			end
		end
	end

	assign push = scan_push || flush_push || resp_push;

	always_ff @(posedge clk) begin
		if (rd_en) rdata_s1 <= mem[iss_q[IW-1:0]];
		if (wr_en) mem[wr_idx] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			key_q <= station_id;
			lvl_q <= signal_dbm;
			now_q <= now_ms;
		end
		if (advance && rd_en) ev_idx_s1 <= iss_q[IW-1:0];
		if (advance && match) begin
			hit_idx_q   <= ev_idx_s1;
			hit_cell_q  <= rdata_s1.cell_id;
			hit_level_q <= rdata_s1.level;
		end
		if (advance && empty && !free_found_q) free_idx_q <= ev_idx_s1;
		if (advance && remove) pend_cell_q <= rdata_s1.cell_id;
		if (push) begin
			out_ev_q    <= push_ev;
			out_cell_q  <= push_cell;
			out_level_q <= push_level;
			out_last_q  <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			iss_q        <= '0;
			ev_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pend_q       <= 1'b0;
			counter_q    <= '0;
			thr_q        <= clt_pkg::STALE_RESET_MS;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) thr_q <= cfg_data;
			if (ctl.load) begin
				iss_q        <= '0;
				ev_valid_s1  <= 1'b0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				pend_q       <= 1'b0;
			end else if (advance) begin
				ev_valid_s1 <= rd_en;
				if (rd_en) iss_q <= iss_q + 1'b1;
				if (match) hit_q <= 1'b1;
				if (empty) free_found_q <= 1'b1;
				if (remove) begin
					valid_q[ev_idx_s1] <= 1'b0;
					pend_q             <= 1'b1;
				end
			end else if (flush_push) begin
				pend_q <= 1'b0;
			end
			if (ins_en) begin
				valid_q[free_idx_q] <= 1'b1;
				counter_q           <= next_cell;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.scan_done = (iss_q == DEPTH_C) && !ev_valid_s1;
		st.is_tick   = is_tick;
		st.out_free  = out_free;
		st.pend      = pend_q;
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign event_res   = out_ev_q;
	assign cell_number = out_cell_q;
	assign level_dbm   = out_level_q;
	assign last        = out_last_q;

	`CLT_ASSERT_IMP(a_scan_bound, 1'b1, iss_q <= DEPTH_C, "scan index beyond table depth")
	`CLT_ASSERT_IMP(a_insert_free, ins_en, !valid_q[free_idx_q], "insert into a live slot")
	`CLT_ASSERT_NXT(a_flush_clears, flush_push, !pend_q && out_last_q, "flush left a pending loss")
	`CLT_ASSERT_IMP(a_counter_step, !$stable(counter_q), $past(ins_en) || $past(!arst_n),
		"cell counter moved without an insert")

endmodule

@@ hdl/cell_liveness_table_unit.sv @@
// ----------------------------------------------------------------------------
// Cell liveness table unit
// Table of known cells keyed by station id, with heartbeat insert and
// refresh, message forwarding and aging sweep.
// ----------------------------------------------------------------------------
// channel  handshake             payload
// in       in_valid / in_ready   command, station_id, signal_dbm, now_ms
// out      out_valid / out_ready event_res, cell_number, level_dbm, last
// cfg      cfg_valid / cfg_ready cfg_data (stale threshold, ms)
//
// Every item scans the entry memory one slot per cycle, save while an aging
// sweep stalls on out, through its single read port; in_ready rises again only
// once the item is done, which takes longer while out stalls.
// An aging sweep holds its scan when a second loss waits on a full output.
// Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cell_liveness_table_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [63:0]        station_id,
	input  logic signed [15:0] signal_dbm,
	input  logic [31:0]        now_ms,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_res,
	output logic [31:0]        cell_number,
	output logic signed [15:0] level_dbm,
	output logic               last
);

	clt_pkg::ctl_t  ctl;
	clt_pkg::stat_t st;

	clt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	clt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.st          (st),
		.command     (command),
		.station_id  (station_id),
		.signal_dbm  (signal_dbm),
		.now_ms      (now_ms),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.cell_number (cell_number),
		.level_dbm   (level_dbm),
		.last        (last)
	);

endmodule
